[design/kwt_pkg.sv]
// Shared types and constants of the keyword and number tokenizer.
package kwt_pkg;

  // Width of the internal line and column counters.
  localparam int PosBits = 32;

  // Width of the line and column fields on the result port.
  localparam int OutPosBits = 32;

  // Depth of the result queue and the widths that follow from it.
  localparam int QDepth = 4;
  localparam int QPtrBits = $clog2(QDepth);
  localparam int QCntBits = $clog2(QDepth + 1);

  // Result kinds.
  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_KW1    = 3'd1;
  localparam logic [2:0] KIND_KW2    = 3'd2;
  localparam logic [2:0] KIND_EOF    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_WORD     = 2'd1;
  localparam logic [1:0] ERR_BYTE     = 2'd2;
  localparam logic [1:0] ERR_RANGE    = 2'd3;

  // One result item as it sits in the queue.
  typedef struct packed {
    logic [2:0]            kind;
    logic [63:0]           value;
    logic [OutPosBits-1:0] line;
    logic [OutPosBits-1:0] column;
    logic [1:0]            error_code;
    logic [7:0]            bad_byte;
    logic                  last;
  } res_t;

endpackage

[design/keyword_number_tokenizer.sv]
// Tokenizer for signed decimal numbers and two keywords, one source byte per item.
//
// Each input item is one source byte or the end marker and is decoded in the cycle it is
// accepted; while the input is ready the block takes one item per clock. An item gives
// zero, one or two result items, which go into a four-entry result queue whose head
// drives the result port; a result is registered into the queue, so it reaches the port
// at the earliest in the cycle after its input item is accepted. The input is ready while
// at least two queue entries are free, so a steady rate of one item per cycle holds as
// long as results are taken as fast as they arise. After reset the block is ready at once.
module keyword_number_tokenizer
  import kwt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_byte_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic signed [63:0] out_value,
  output logic [31:0]        out_line,
  output logic [31:0]        out_column,
  output logic [1:0]         out_error_code,
  output logic [7:0]         out_bad_byte,
  output logic               out_last
);

  // Tokenizer modes.
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_MINUS   = 3'd2;
  localparam logic [2:0] M_NUMBER  = 3'd3;
  localparam logic [2:0] M_WORD    = 3'd4;
  localparam logic [2:0] M_ERROR   = 3'd5;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [63:0] LimMag    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LimDiv10  = LimMag / 10;
  localparam logic [PosBits-1:0] PosMax = '1;
  localparam logic [PosBits-1:0] PosOne = PosBits'(1);
  localparam int ExtBits = (PosBits > OutPosBits) ? PosBits : OutPosBits;

  // Spellings of the two keywords; the second is padded to eight bytes.
  localparam logic [7:0] KW1 [8] = '{8'h61, 8'h68, 8'h6C, 8'h65, 8'h6C, 8'h65, 8'h6C, 8'h65};
  localparam logic [7:0] KW2 [8] = '{8'h61, 8'h68, 8'h6C, 8'h65, 8'h6C, 8'h61, 8'h73, 8'h00};

  // Clamp a position to the width of the result port.
  function automatic logic [OutPosBits-1:0] clamp_pos(input logic [PosBits-1:0] p);
    logic [ExtBits-1:0] pe;
    logic [ExtBits-1:0] lim;
    begin
      pe  = ExtBits'(p);
      lim = ExtBits'({OutPosBits{1'b1}});
      clamp_pos = (pe > lim) ? OutPosBits'(lim) : OutPosBits'(pe);
    end
  endfunction

  // Accumulate one decimal digit; the top bit of the result is the overflow flag.
  function automatic logic [64:0] add_digit(input logic [63:0] mag, input logic ovf,
                                            input logic [7:0] b);
    logic [63:0] prod;
    begin
      prod = (mag << 3) + (mag << 1) + {60'd0, b[3:0]};
      if (ovf || (mag > LimDiv10)) begin
        add_digit = {1'b1, mag};
      end else begin
        add_digit = {(prod > LimMag), prod};
      end
    end
  endfunction

  // Track one letter against both keywords; returns {length, candidates}.
  function automatic logic [5:0] add_letter(input logic [3:0] len, input logic [1:0] cand,
                                            input logic [7:0] b);
    logic [1:0] c;
    logic [3:0] l;
    begin
      c = cand;
      if (!((len < 4'd8) && (KW1[len[2:0]] == b))) c[0] = 1'b0;
      if (!((len < 4'd7) && (KW2[len[2:0]] == b))) c[1] = 1'b0;
      l = (len < 4'd15) ? (len + 4'd1) : len;
      add_letter = {l, c};
    end
  endfunction

  // Build one result item.
  function automatic res_t make_res(input logic [2:0] kind, input logic [63:0] value,
                                    input logic [1:0] code, input logic [7:0] bad,
                                    input logic [PosBits-1:0] sl,
                                    input logic [PosBits-1:0] sc);
    res_t r;
    begin
      r.kind       = kind;
      r.value      = value;
      r.line       = clamp_pos(sl);
      r.column     = clamp_pos(sc);
      r.error_code = code;
      r.bad_byte   = bad;
      r.last       = 1'b0;
      make_res     = r;
    end
  endfunction

  logic [2:0]         mode_r, mode_nxt;
  logic [63:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic               ovf_r, ovf_nxt;
  logic [3:0]         wlen_r, wlen_nxt;
  logic [1:0]         cand_r, cand_nxt;
  logic [PosBits-1:0] cur_line_r, cur_line_nxt;
  logic [PosBits-1:0] cur_col_r, cur_col_nxt;
  logic [PosBits-1:0] start_line_r, start_line_nxt;
  logic [PosBits-1:0] start_col_r, start_col_nxt;

  res_t       res [2];
  logic [1:0] res_n;
  logic       accept;
  logic       room_for_two;
  logic       head_valid;
  res_t       head_data;

  assign in_ready = room_for_two;
  assign accept   = in_valid && in_ready;

  // Decode one item: finish a pending token, start a new one, move the position.
  always_comb begin
    logic       fin;
    logic       st;
    logic       is_digit;
    logic       is_alpha;
    logic       is_space;
    logic [7:0] b;
    logic [64:0] dig;
    logic [5:0]  let_r;

    b        = in_byte_req;
    is_digit = b inside {[8'h30:8'h39]};
    is_alpha = b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_space = b inside {8'h20, [8'h09:8'h0D]};

    mode_nxt       = mode_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    ovf_nxt        = ovf_r;
    wlen_nxt       = wlen_r;
    cand_nxt       = cand_r;
    cur_line_nxt   = cur_line_r;
    cur_col_nxt    = cur_col_r;
    start_line_nxt = start_line_r;
    start_col_nxt  = start_col_r;
    res[0]         = '0;
    res[1]         = '0;
    res_n          = 2'd0;
    fin            = 1'b0;
    st             = 1'b0;
    dig            = '0;
    let_r          = '0;

    // Mode step for a source byte; the end marker only completes what is pending.
    if (in_func) begin
      fin = (mode_r == M_NUMBER) || (mode_r == M_WORD);
    end else begin
      case (mode_r)
        M_ERROR: begin
        end
        M_COMMENT: begin
          if (b == CH_LF) mode_nxt = M_IDLE;
        end
        M_MINUS: begin
          if (is_digit) begin
            mode_nxt = M_NUMBER;
            dig      = add_digit(mag_r, ovf_r, b);
            ovf_nxt  = dig[64];
            mag_nxt  = dig[63:0];
          end else begin
            mode_nxt = M_IDLE;
            st       = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            dig     = add_digit(mag_r, ovf_r, b);
            ovf_nxt = dig[64];
            mag_nxt = dig[63:0];
          end else begin
            fin = 1'b1;
            st  = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha) begin
            let_r    = add_letter(wlen_r, cand_r, b);
            wlen_nxt = let_r[5:2];
            cand_nxt = let_r[1:0];
          end else begin
            fin = 1'b1;
            st  = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          st       = 1'b1;
        end
      endcase
    end

    // Complete a pending number or word.
    if (fin) begin
      if (mode_r == M_NUMBER) begin
        if (ovf_r || (!neg_r && mag_r[63])) begin
          res[res_n[0]] = make_res(KIND_ERROR, '0, ERR_RANGE, '0, start_line_r, start_col_r);
          mode_nxt      = M_ERROR;
        end else begin
          res[res_n[0]] = make_res(KIND_NUMBER, neg_r ? (64'd0 - mag_r) : mag_r, ERR_NONE,
                                   '0, start_line_r, start_col_r);
          mode_nxt      = M_IDLE;
        end
      end else begin
        if (cand_r[0] && (wlen_r == 4'd8)) begin
          res[res_n[0]] = make_res(KIND_KW1, '0, ERR_NONE, '0, start_line_r, start_col_r);
          mode_nxt      = M_IDLE;
        end else if (cand_r[1] && (wlen_r == 4'd7)) begin
          res[res_n[0]] = make_res(KIND_KW2, '0, ERR_NONE, '0, start_line_r, start_col_r);
          mode_nxt      = M_IDLE;
        end else begin
          res[res_n[0]] = make_res(KIND_ERROR, '0, ERR_WORD, '0, start_line_r, start_col_r);
          mode_nxt      = M_ERROR;
        end
      end
      res_n = res_n + 2'd1;
    end

    // Handle the byte as one that arrives between tokens.
    if (st && (mode_nxt != M_ERROR) && !is_space) begin
      start_line_nxt = cur_line_r;
      start_col_nxt  = cur_col_r;
      if (b == CH_HASH) begin
        mode_nxt = M_COMMENT;
      end else if (is_digit) begin
        mode_nxt = M_NUMBER;
        neg_nxt  = 1'b0;
        dig      = add_digit('0, 1'b0, b);
        ovf_nxt  = dig[64];
        mag_nxt  = dig[63:0];
      end else if (b == CH_MINUS) begin
        mode_nxt = M_MINUS;
        neg_nxt  = 1'b1;
        ovf_nxt  = 1'b0;
        mag_nxt  = '0;
      end else if (is_alpha) begin
        mode_nxt = M_WORD;
        let_r    = add_letter(4'd0, 2'b11, b);
        wlen_nxt = let_r[5:2];
        cand_nxt = let_r[1:0];
      end else begin
        res[res_n[0]] = make_res(KIND_ERROR, '0, ERR_BYTE, b, cur_line_r, cur_col_r);
        res_n         = res_n + 2'd1;
        mode_nxt      = M_ERROR;
      end
    end

    // End of source gives the end-of-file item and returns to the reset state.
    if (in_func) begin
      res[res_n[0]]  = make_res(KIND_EOF, '0, ERR_NONE, '0, cur_line_r, cur_col_r);
      res_n          = res_n + 2'd1;
      mode_nxt       = M_IDLE;
      mag_nxt        = '0;
      neg_nxt        = 1'b0;
      ovf_nxt        = 1'b0;
      wlen_nxt       = '0;
      cand_nxt       = 2'b11;
      cur_line_nxt   = PosOne;
      cur_col_nxt    = PosOne;
      start_line_nxt = PosOne;
      start_col_nxt  = PosOne;
    end else if (b == CH_LF) begin
      if (cur_line_r != PosMax) cur_line_nxt = cur_line_r + PosOne;
      cur_col_nxt = PosOne;
    end else if (cur_col_r != PosMax) begin
      cur_col_nxt = cur_col_r + PosOne;
    end

    // Mark the final result of this item.
    if (res_n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (res_n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  // Tokenizer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      mag_r        <= '0;
      neg_r        <= 1'b0;
      ovf_r        <= 1'b0;
      wlen_r       <= '0;
      cand_r       <= 2'b11;
      cur_line_r   <= PosOne;
      cur_col_r    <= PosOne;
      start_line_r <= PosOne;
      start_col_r  <= PosOne;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      mag_r        <= mag_nxt;
      neg_r        <= neg_nxt;
      ovf_r        <= ovf_nxt;
      wlen_r       <= wlen_nxt;
      cand_r       <= cand_nxt;
      cur_line_r   <= cur_line_nxt;
      cur_col_r    <= cur_col_nxt;
      start_line_r <= start_line_nxt;
      start_col_r  <= start_col_nxt;
    end
  end

  // Result queue in front of the result port.
  kwt_res_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_n       (accept ? res_n : 2'd0),
    .push_data    (res),
    .pop          (out_ready),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .room_for_two (room_for_two)
  );

  assign out_valid      = head_valid;
  assign out_kind       = head_data.kind;
  assign out_value      = signed'(head_data.value);
  assign out_line       = head_data.line;
  assign out_column     = head_data.column;
  assign out_error_code = head_data.error_code;
  assign out_bad_byte   = head_data.bad_byte;
  assign out_last       = head_data.last;

endmodule

[design/kwt_res_queue.sv]
// Small result queue that takes up to two items per cycle and gives one.
module kwt_res_queue
  import kwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push_data [2],
  input  logic       pop,
  output logic       head_valid,
  output res_t       head_data,
  output logic       room_for_two
);

  res_t                entry_r [QDepth];
  logic [QPtrBits-1:0] wptr_r, wptr_nxt;
  logic [QPtrBits-1:0] rptr_r, rptr_nxt;
  logic [QCntBits-1:0] count_r, count_nxt;
  logic [QPtrBits-1:0] wptr_plus1;
  logic                do_pop;

  assign head_valid   = (count_r != '0);
  assign head_data    = entry_r[rptr_r];
  assign room_for_two = (count_r <= QCntBits'(QDepth - 2));
  assign do_pop       = pop && head_valid;
  assign wptr_plus1   = wptr_r + QPtrBits'(1);

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt  = wptr_r + QPtrBits'(push_n);
    rptr_nxt  = do_pop ? (rptr_r + QPtrBits'(1)) : rptr_r;
    count_nxt = count_r + QCntBits'(push_n) - QCntBits'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage: the first new item goes to the write pointer, a second one just after it.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry_r[wptr_r] <= push_data[0];
    end
    if (push_n == 2'd2) begin
      entry_r[wptr_plus1] <= push_data[1];
    end
  end

endmodule

[sim/keyword_number_tokenizer_test.sv]
// Self-checking testbench for the keyword and number tokenizer, with a built-in lexer predictor.
module keyword_number_tokenizer_test;
  import kwt_pkg::*;

  localparam int FEED_TARGET  = 650;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [63:0]        MAG_LIMIT   = 64'h8000_0000_0000_0000;
  localparam logic [PosBits-1:0] POS_TOP     = '1;
  localparam logic [63:0]        KW_ONE_TEXT = {"ahlel", "ele"};
  localparam logic [55:0]        KW_TWO_TEXT = "ahlelas";
  localparam logic [7:0]         LF          = 8'h0A;

  localparam logic [7:0] BLANKS [6]    = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  localparam logic [7:0] KW_LETTERS [5] = '{"a", "h", "l", "e", "s"};

  typedef enum logic [2:0] {
    LX_IDLE, LX_COMMENT, LX_MINUS, LX_NUMBER, LX_WORD, LX_ERROR
  } lex_mode_t;

  // One row of the directed stimulus; want is used only where typed is set.
  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       typed;
    res_t       want;
  } row_t;

  localparam res_t NO_RES = '0;

  localparam row_t DIRECTED_ROWS [22] = '{
    '{1'b1, 8'h00, 1'b1, '{KIND_EOF, 64'd0, 32'd1, 32'd1, ERR_NONE, 8'h00, 1'b1}},
    '{1'b0, 8'hFF, 1'b1, '{KIND_ERROR, 64'd0, 32'd1, 32'd1, ERR_BYTE, 8'hFF, 1'b1}},
    '{1'b0, "7",   1'b0, NO_RES},
    '{1'b1, 8'hA5, 1'b1, '{KIND_EOF, 64'd0, 32'd1, 32'd3, ERR_NONE, 8'h00, 1'b1}},
    '{1'b0, "#",   1'b0, NO_RES},
    '{1'b0, 8'h80, 1'b0, NO_RES},
    '{1'b0, 8'h0A, 1'b0, NO_RES},
    '{1'b0, "-",   1'b0, NO_RES},
    '{1'b0, " ",   1'b0, NO_RES},
    '{1'b0, "-",   1'b0, NO_RES},
    '{1'b0, "5",   1'b0, NO_RES},
    '{1'b0, "Z",   1'b0, NO_RES},
    '{1'b1, 8'h5A, 1'b0, NO_RES},
    '{1'b0, "4",   1'b0, NO_RES},
    '{1'b0, "2",   1'b0, NO_RES},
    '{1'b1, 8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h0D, 1'b0, NO_RES},
    '{1'b0, "-",   1'b0, NO_RES},
    '{1'b1, 8'h00, 1'b1, '{KIND_EOF, 64'd0, 32'd1, 32'd3, ERR_NONE, 8'h00, 1'b1}},
    '{1'b0, "9",   1'b0, NO_RES},
    '{1'b0, "$",   1'b0, NO_RES},
    '{1'b1, 8'hC3, 1'b0, NO_RES}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_func;
  logic [7:0]         in_byte_req;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_kind;
  logic signed [63:0] out_value;
  logic [31:0]        out_line;
  logic [31:0]        out_column;
  logic [1:0]         out_error_code;
  logic [7:0]         out_bad_byte;
  logic               out_last;

  // Lexer state of the predictor.
  lex_mode_t          lx_mode;
  logic [63:0]        num_mag;
  logic               num_neg;
  logic               num_ovf;
  logic [3:0]         word_len;
  logic [1:0]         kw_alive;
  logic [PosBits-1:0] cur_ln;
  logic [PosBits-1:0] cur_col;
  logic [PosBits-1:0] tok_ln;
  logic [PosBits-1:0] tok_col;

  res_t       step_out [2];
  int         step_n;
  res_t       tokens_due [$];
  res_t       want_tok;
  logic [7:0] src_text [$];
  int         mismatches = 0;
  int         accepted_items = 0;
  int         pace = 0;
  int         quiet_cycles = 0;

  keyword_number_tokenizer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_byte_req    (in_byte_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_line       (out_line),
    .out_column     (out_column),
    .out_error_code (out_error_code),
    .out_bad_byte   (out_bad_byte),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character classes of the source language.
  function automatic bit is_blank(logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic logic [7:0] kw_char(bit second, int idx);
    return second ? KW_TWO_TEXT[55 - 8 * idx -: 8] : KW_ONE_TEXT[63 - 8 * idx -: 8];
  endfunction

  // Return the lexer to its state after reset.
  function automatic void lex_clear();
    lx_mode  = LX_IDLE;
    num_mag  = '0;
    num_neg  = 1'b0;
    num_ovf  = 1'b0;
    word_len = '0;
    kw_alive = 2'b11;
    cur_ln   = 1;
    cur_col  = 1;
    tok_ln   = 1;
    tok_col  = 1;
  endfunction

  function automatic void lex_emit(logic [2:0] kind, logic [63:0] value, logic [1:0] code,
                                   logic [7:0] bad);
    step_out[step_n] = '{kind: kind, value: value, line: tok_ln, column: tok_col,
                         error_code: code, bad_byte: bad, last: 1'b0};
    step_n++;
  endfunction

  function automatic void lex_mark();
    tok_ln  = cur_ln;
    tok_col = cur_col;
  endfunction

  // Accumulate one decimal digit; anything beyond 2^63 is flagged and then frozen.
  function automatic void lex_digit(logic [7:0] ch);
    if (num_ovf) return;
    if (num_mag > MAG_LIMIT / 10) begin
      num_ovf = 1'b1;
      return;
    end
    num_mag = num_mag * 64'd10 + 64'(ch - 8'h30);
    if (num_mag > MAG_LIMIT) num_ovf = 1'b1;
  endfunction

  // Narrow down which keywords the word can still be.
  function automatic void lex_letter(logic [7:0] ch);
    bit one_ok;
    bit two_ok;
    one_ok = 1'b0;
    two_ok = 1'b0;
    if (word_len < 8) one_ok = (kw_char(1'b0, int'(word_len)) == ch);
    if (word_len < 7) two_ok = (kw_char(1'b1, int'(word_len)) == ch);
    if (!one_ok) kw_alive[0] = 1'b0;
    if (!two_ok) kw_alive[1] = 1'b0;
    if (word_len < 15) word_len++;
  endfunction

  // Complete a pending number or word.
  function automatic void lex_close();
    if (lx_mode == LX_NUMBER) begin
      if (num_ovf || (!num_neg && num_mag > MAG_LIMIT - 1)) begin
        lex_emit(KIND_ERROR, '0, ERR_RANGE, '0);
        lx_mode = LX_ERROR;
        return;
      end
      lex_emit(KIND_NUMBER, num_neg ? 64'd0 - num_mag : num_mag, ERR_NONE, '0);
    end else if (lx_mode == LX_WORD) begin
      if (kw_alive[0] && word_len == 8) begin
        lex_emit(KIND_KW1, '0, ERR_NONE, '0);
      end else if (kw_alive[1] && word_len == 7) begin
        lex_emit(KIND_KW2, '0, ERR_NONE, '0);
      end else begin
        lex_emit(KIND_ERROR, '0, ERR_WORD, '0);
        lx_mode = LX_ERROR;
        return;
      end
    end
    lx_mode = LX_IDLE;
  endfunction

  // A byte that arrives between tokens.
  function automatic void lex_fresh(logic [7:0] ch);
    if (is_blank(ch)) return;
    lex_mark();
    if (ch == "#") begin
      lx_mode = LX_COMMENT;
    end else if (is_digit(ch)) begin
      lx_mode = LX_NUMBER;
      num_neg = 1'b0;
      num_ovf = 1'b0;
      num_mag = '0;
      lex_digit(ch);
    end else if (ch == "-") begin
      lx_mode = LX_MINUS;
      num_neg = 1'b1;
      num_ovf = 1'b0;
      num_mag = '0;
    end else if (is_letter(ch)) begin
      lx_mode  = LX_WORD;
      word_len = '0;
      kw_alive = 2'b11;
      lex_letter(ch);
    end else begin
      lex_emit(KIND_ERROR, '0, ERR_BYTE, ch);
      lx_mode = LX_ERROR;
    end
  endfunction

  // Line and column move with every source byte and saturate.
  function automatic void lex_advance(logic [7:0] ch);
    if (ch == LF) begin
      if (cur_ln < POS_TOP) cur_ln++;
      cur_col = 1;
    end else if (cur_col < POS_TOP) begin
      cur_col++;
    end
  endfunction

  // Work out the results of one accepted item into step_out.
  function automatic void lex_step(logic func, logic [7:0] ch);
    step_n = 0;
    if (func) begin
      if (lx_mode == LX_NUMBER || lx_mode == LX_WORD) lex_close();
      lex_mark();
      lex_emit(KIND_EOF, '0, ERR_NONE, '0);
      lex_clear();
    end else begin
      case (lx_mode)
        LX_ERROR: begin
          // Source bytes are dropped until the end marker.
        end
        LX_COMMENT: begin
          if (ch == LF) lx_mode = LX_IDLE;
        end
        LX_MINUS: begin
          if (is_digit(ch)) begin
            lx_mode = LX_NUMBER;
            lex_digit(ch);
          end else begin
            lx_mode = LX_IDLE;
            lex_fresh(ch);
          end
        end
        LX_NUMBER: begin
          if (is_digit(ch)) begin
            lex_digit(ch);
          end else begin
            lex_close();
            if (lx_mode != LX_ERROR) lex_fresh(ch);
          end
        end
        LX_WORD: begin
          if (is_letter(ch)) begin
            lex_letter(ch);
          end else begin
            lex_close();
            if (lx_mode != LX_ERROR) lex_fresh(ch);
          end
        end
        default: begin
          lx_mode = LX_IDLE;
          lex_fresh(ch);
        end
      endcase
      lex_advance(ch);
    end
    if (step_n > 0) step_out[step_n - 1].last = 1'b1;
  endfunction

  // Idle and stall rates for the current phase of the run.
  function automatic bit feed_pauses();
    case (pace)
      1: return $urandom_range(0, 99) < 60;
      3: return $urandom_range(0, 99) < 33;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit sink_pauses();
    case (pace)
      2: return $urandom_range(0, 99) < 60;
      3: return $urandom_range(0, 99) < 33;
      default: return 1'b0;
    endcase
  endfunction

  // Offer one item from a falling edge, wait for it to be taken and record what it should give.
  task automatic push_item(input logic func, input logic [7:0] data, input logic typed,
                           input res_t typed_res);
    while (feed_pauses()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_byte_req <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted_items++;
    pace = (accepted_items / 160) % 4;
    lex_step(func, data);
    if (typed) begin
      tokens_due.insert(tokens_due.size(), typed_res);
    end else begin
      for (int i = 0; i < step_n; i++) tokens_due.insert(tokens_due.size(), step_out[i]);
    end
    @(negedge clk);
  endtask

  task automatic send_text();
    while (src_text.size() != 0) push_item(1'b0, src_text.pop_front(), 1'b0, NO_RES);
  endtask

  // Append one byte to the pending source text.
  function automatic void put_src(logic [7:0] ch);
    src_text.insert(src_text.size(), ch);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) put_src(s[i]);
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(1, 3)) put_src(BLANKS[$urandom_range(0, 5)]);
  endfunction

  // Letters biased towards those the keywords are made of.
  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return KW_LETTERS[$urandom_range(0, 4)];
    if (r < 80) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  // Numbers: mostly short, some long enough to overflow, and the edges of the range.
  function automatic void add_number();
    int unsigned n;
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 5))
        0: add_text("9223372036854775807");
        1: add_text("-9223372036854775808");
        2: add_text("9223372036854775808");
        3: add_text("-9223372036854775809");
        4: add_text("18446744073709551616");
        default: add_text("-0000000000000000000000042");
      endcase
    end else begin
      if ($urandom_range(0, 99) < 35) put_src("-");
      n = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 21);
      repeat (n) put_src(8'("0" + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_keyword(bit second);
    for (int i = 0; i < (second ? 7 : 8); i++) put_src(kw_char(second, i));
  endfunction

  // Words that mostly come close to a keyword without being one, or random letter runs.
  function automatic void add_near_miss();
    logic [7:0]  w [$];
    bit          second;
    int unsigned n;
    int unsigned pos;
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(1, 18)) w.insert(w.size(), rand_letter());
      end
      1: begin
        second = $urandom_range(0, 1);
        for (int i = 0; i < (second ? 7 : 8); i++) w.insert(w.size(), kw_char(second, i));
        pos = $urandom_range(0, w.size() - 1);
        w[pos] = $urandom_range(0, 1) ? (w[pos] ^ 8'h20) : rand_letter();
      end
      2: begin
        second = $urandom_range(0, 1);
        for (int i = 0; i < (second ? 7 : 8); i++) w.insert(w.size(), kw_char(second, i));
        n = $urandom_range(1, w.size() - 1);
        while (w.size() > n) void'(w.pop_back());
      end
      default: begin
        second = $urandom_range(0, 1);
        for (int i = 0; i < (second ? 7 : 8); i++) w.insert(w.size(), kw_char(second, i));
        repeat ($urandom_range(1, 9)) w.insert(w.size(), rand_letter());
      end
    endcase
    foreach (w[i]) put_src(w[i]);
  endfunction

  // Comment body of arbitrary bytes; now and then the end marker cuts it short.
  function automatic void add_comment();
    logic [7:0] ch;
    put_src("#");
    repeat ($urandom_range(0, 10)) begin
      ch = 8'($urandom_range(0, 255));
      put_src(ch == LF ? 8'h0B : ch);
    end
    if ($urandom_range(0, 99) < 90) put_src(LF);
  endfunction

  // One source text of a few tokens, closed by the end marker.
  task automatic make_source();
    int unsigned ntok;
    int unsigned pick;
    bit          stop;
    ntok = $urandom_range(1, 14);
    stop = 1'b0;
    for (int t = 0; t < ntok && !stop; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) add_number();
      else if (pick < 44) add_keyword(1'b0);
      else if (pick < 56) add_keyword(1'b1);
      else if (pick < 68) add_near_miss();
      else if (pick < 76) add_comment();
      else if (pick < 82) put_src("-");
      else if (pick < 87) add_blanks();
      else if (pick < 92) put_src(8'($urandom_range(0, 255)));
      else stop = 1'b1;
      if ($urandom_range(0, 99) < 75) add_blanks();
    end
    send_text();
    push_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
  endtask

  // Stimulus: reset, the directed rows, then random source texts, then drain.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = 1'b0;
    in_byte_req = 8'h00;
    lex_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[r]) begin
      push_item(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].typed,
                DIRECTED_ROWS[r].want);
    end
    while (accepted_items < FEED_TARGET) make_source();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The result side stalls at random according to the phase.
  always @(negedge clk) begin
    out_ready <= !sink_pauses();
  end

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result item with the oldest one outstanding.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: result item of kind %0d arrived with none outstanding", $time, out_kind);
        mismatches++;
      end else begin
        want_tok = tokens_due.pop_front();
        check_field("kind", 64'(want_tok.kind), 64'(out_kind));
        check_field("value", want_tok.value, out_value);
        check_field("line", 64'(want_tok.line), 64'(out_line));
        check_field("column", 64'(want_tok.column), 64'(out_column));
        check_field("error_code", 64'(want_tok.error_code), 64'(out_error_code));
        check_field("bad_byte", 64'(want_tok.bad_byte), 64'(out_bad_byte));
        check_field("last", 64'(want_tok.last), 64'(out_last));
      end
    end
  end

  // Give up if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sim.f]
design/kwt_pkg.sv
design/kwt_res_queue.sv
design/keyword_number_tokenizer.sv
sim/keyword_number_tokenizer_test.sv
